[sv/assert_macros.svh]
// Assertion macros used by the RTL top level of the cumulative frequency model.
// Expects i_clk and i_rst_n in the scope of use.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked at every clock edge out of reset.
`define ASSERT_SYNC(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) \
        else $error(msg);

// Consequent checked in the cycle after the antecedent.
`define ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[sv/acfm_pkg.sv]
// Types and constants of the adaptive cumulative frequency model.
// No dependencies.
`default_nettype none

package acfm_pkg;

    localparam int          MAX_ENTRIES_DEF = 512;
    localparam logic [15:0] ESCAPE_CODE     = 16'd256;
    localparam logic [15:0] COUNT_MAX       = 16'hFFFF;

    localparam logic [1:0] MODE_ENCODE = 2'd0;
    localparam logic [1:0] MODE_DECODE = 2'd1;
    localparam logic [1:0] MODE_UPDATE = 2'd2;
    localparam logic [1:0] MODE_NONE   = 2'd3;

    typedef struct packed {
        logic [1:0]  mode;
        logic [15:0] symbol_code;
        logic [15:0] target_count;
        logic [15:0] scale_in;
    } t_in;

    typedef struct packed {
        logic [15:0] found_code;
        logic [15:0] cum_lo;
        logic [15:0] cum_hi;
        logic [15:0] scale_out;
        logic        escaped;
        logic        refused;
    } t_out;

    typedef struct packed {
        logic [15:0] code;
        logic [15:0] cum;
    } t_entry;

endpackage

`default_nettype wire

[sv/adaptive_cumulative_frequency_model.sv]
// Adaptive cumulative frequency model for an arithmetic coder, top level.
// Depends on acfm_pkg, acfm_ram and assert_macros.svh.
//
// Input channel (i_in_valid / o_in_ready, payload i_in_data) takes one
// transaction per request: encode lookup, decode lookup, update or unused mode.
// Output channel (o_out_valid / i_out_ready, payload o_out_data) returns
// exactly one result transaction per request, in order.
// The table (code, cumulative count) lives in one synchronous RAM.
// Sequence of work, with N entries in use:
//   encode / decode : one linear scan of the N entries, one entry a cycle.
//   update          : a scan, then, unless refused, an increment pass up to the
//                     matched entry (all, for a new symbol), then a read and a
//                     check for every place the entry moves up, and a final write.
//   unused mode     : no scan; the result goes straight to the output stage.
// One request is in flight at a time; the RAM port sets the pace.
// Reset: one cycle after reset release writes the escape entry to slot 0;
// o_in_ready stays low during it.
// Output stall: the result sits in an output register; a finished request
// waits until that register frees, and a new request is taken while a
// result still waits to be taken.
`default_nettype none

module adaptive_cumulative_frequency_model
    import acfm_pkg::*;
#(
    parameter int MAX_ENTRIES = MAX_ENTRIES_DEF
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_in_valid,
    output logic      o_in_ready,
    input  wire t_in  i_in_data,
    output logic      o_out_valid,
    input  wire logic i_out_ready,
    output t_out      o_out_data
);

    localparam int IW = $clog2(MAX_ENTRIES);
    localparam int UW = $clog2(MAX_ENTRIES + 1);

    typedef enum logic [3:0] {
        S_INIT, S_IDLE, S_SCAN, S_INCR, S_BUBRD, S_BUBCHK, S_BUBEND, S_OUT
    } t_state;

    t_state r_state;

    // model state
    logic [UW-1:0] r_used;
    logic [15:0]   r_total;

    // request and pending result
    t_in  r_req;
    t_out r_res;
    logic r_out_vld;
    t_out r_out_data;

    // scan / pass sequencing
    logic [IW-1:0] r_addr, r_last, r_ridx;
    logic          r_issue_done, r_rvld;

    // selected entry (symbol match or decode hit) and escape entry
    logic          r_sel_found, r_sel_want;
    logic [IW-1:0] r_sel_idx;
    logic [15:0]   r_sel_code, r_sel_cum, r_sel_next;
    logic          r_esc_found, r_esc_want;
    logic [15:0]   r_esc_cum, r_esc_next;

    // bubble
    logic [IW-1:0] r_pos;
    logic [15:0]   r_own, r_cur_cum;

    // RAM ports
    logic          ram_we, ram_re;
    logic [IW-1:0] ram_waddr, ram_raddr;
    t_entry        ram_wdata, ram_rdata;
    logic [31:0]   ram_rbits;

    acfm_ram #(
        .DEPTH(MAX_ENTRIES),
        .AW   (IW),
        .DW   ($bits(t_entry))
    ) u_ram (
        .i_clk  (i_clk),
        .i_we   (ram_we),
        .i_waddr(ram_waddr),
        .i_wdata(ram_wdata),
        .i_re   (ram_re),
        .i_raddr(ram_raddr),
        .o_rdata(ram_rbits)
    );

    assign ram_rdata = t_entry'(ram_rbits);

    logic pass_done;
    logic match_sel, match_esc;
    logic [15:0] above;
    t_out n_res;
    logic upd_go;
    logic out_load;

    assign pass_done = r_issue_done && !r_rvld;
    assign above     = ram_rdata.cum - r_cur_cum;
    assign match_sel = (r_req.mode == MODE_DECODE)
                     ? (ram_rdata.cum > r_req.target_count || r_ridx == '0)
                     : (!r_sel_found && ram_rdata.code == r_req.symbol_code);
    assign match_esc = !r_esc_found && ram_rdata.code == ESCAPE_CODE;

    // result once the scan is over
    always_comb begin
        n_res = '0;
        unique case (r_req.mode)
            MODE_ENCODE: begin
                n_res.scale_out = r_total;
                if (r_sel_found) begin
                    n_res.found_code = r_sel_code;
                    n_res.cum_lo     = r_sel_next;
                    n_res.cum_hi     = r_sel_cum;
                end else begin
                    n_res.found_code = ESCAPE_CODE;
                    n_res.cum_lo     = r_esc_next;
                    n_res.cum_hi     = r_esc_cum;
                    n_res.escaped    = 1'b1;
                end
            end
            MODE_DECODE: begin
                n_res.found_code = r_sel_code;
                n_res.cum_lo     = r_sel_next;
                n_res.cum_hi     = r_sel_cum;
                n_res.scale_out  = r_req.scale_in;
            end
            MODE_UPDATE: begin
                n_res.found_code = r_req.symbol_code;
                if (r_total == COUNT_MAX ||
                    (!r_sel_found && r_used == UW'(MAX_ENTRIES))) begin
                    n_res.scale_out = r_total;
                    n_res.refused   = 1'b1;
                end else begin
                    n_res.scale_out = r_total + 16'd1;
                end
            end
            default: begin
            end
        endcase
    end

    assign upd_go   = (r_req.mode == MODE_UPDATE) && !n_res.refused;
    assign out_load = (r_state == S_OUT) && (!r_out_vld || i_out_ready);

    // RAM read and write selection
    always_comb begin
        ram_re    = 1'b0;
        ram_raddr = r_addr;
        ram_we    = 1'b0;
        ram_waddr = r_ridx;
        ram_wdata = '{code: ram_rdata.code, cum: ram_rdata.cum + 16'd1};
        unique case (r_state)
            S_INIT: begin
                ram_we    = 1'b1;
                ram_waddr = '0;
                ram_wdata = '{code: ESCAPE_CODE, cum: 16'd1};
            end
            S_SCAN: begin
                ram_re = !r_issue_done;
            end
            S_INCR: begin
                ram_re = !r_issue_done;
                if (r_rvld) begin
                    ram_we = 1'b1;
                end else if (pass_done && !r_sel_found) begin
                    // append the new symbol behind the last entry
                    ram_we    = 1'b1;
                    ram_waddr = r_used[IW-1:0];
                    ram_wdata = '{code: r_req.symbol_code, cum: 16'd1};
                end
            end
            S_BUBRD: begin
                ram_re    = 1'b1;
                ram_raddr = r_pos - IW'(1);
            end
            S_BUBCHK: begin
                if (r_own > above) begin
                    ram_we    = 1'b1;
                    ram_waddr = r_pos;
                    ram_wdata = '{code: ram_rdata.code, cum: ram_rdata.cum - r_own};
                end
            end
            S_BUBEND: begin
                ram_we    = 1'b1;
                ram_waddr = r_pos;
                ram_wdata = '{code: r_req.symbol_code, cum: r_cur_cum};
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_INIT;
            r_used       <= UW'(1);
            r_total      <= 16'd1;
            r_out_vld    <= 1'b0;
            r_issue_done <= 1'b1;
            r_rvld       <= 1'b0;
        end else begin
            if (out_load) begin
                r_out_vld <= 1'b1;
            end else if (i_out_ready) begin
                r_out_vld <= 1'b0;
            end

            // shared read issue for the scan and increment passes
            if (r_state == S_SCAN || r_state == S_INCR) begin
                if (!r_issue_done) begin
                    r_ridx <= r_addr;
                    r_rvld <= 1'b1;
                    if (r_addr == r_last) begin
                        r_issue_done <= 1'b1;
                    end else begin
                        r_addr <= r_addr + IW'(1);
                    end
                end else begin
                    r_rvld <= 1'b0;
                end
            end

            unique case (r_state)
                S_INIT: begin
                    r_state <= S_IDLE;
                end
                S_IDLE: begin
                    if (i_in_valid) begin
                        r_req        <= i_in_data;
                        r_addr       <= '0;
                        r_last       <= IW'(r_used - UW'(1));
                        r_issue_done <= 1'b0;
                        r_rvld       <= 1'b0;
                        r_sel_found  <= 1'b0;
                        r_sel_want   <= 1'b0;
                        r_sel_next   <= '0;
                        r_esc_found  <= 1'b0;
                        r_esc_want   <= 1'b0;
                        r_esc_next   <= '0;
                        if (i_in_data.mode == MODE_NONE) begin
                            r_res   <= '0;
                            r_state <= S_OUT;
                        end else begin
                            r_state <= S_SCAN;
                        end
                    end
                end
                S_SCAN: begin
                    if (r_rvld) begin
                        // a new hit supersedes a pending next-count capture
                        if (match_sel) begin
                            r_sel_found <= 1'b1;
                            r_sel_idx   <= r_ridx;
                            r_sel_code  <= ram_rdata.code;
                            r_sel_cum   <= ram_rdata.cum;
                            r_sel_next  <= '0;
                            r_sel_want  <= 1'b1;
                        end else if (r_sel_want) begin
                            r_sel_next <= ram_rdata.cum;
                            r_sel_want <= 1'b0;
                        end
                        if (match_esc) begin
                            r_esc_found <= 1'b1;
                            r_esc_cum   <= ram_rdata.cum;
                            r_esc_next  <= '0;
                            r_esc_want  <= 1'b1;
                        end else if (r_esc_want) begin
                            r_esc_next <= ram_rdata.cum;
                            r_esc_want <= 1'b0;
                        end
                    end else if (pass_done) begin
                        r_res   <= n_res;
                        r_state <= upd_go ? S_INCR : S_OUT;
                        if (upd_go) begin
                            r_total      <= r_total + 16'd1;
                            r_addr       <= '0;
                            r_last       <= r_sel_found ? r_sel_idx
                                                        : IW'(r_used - UW'(1));
                            r_issue_done <= 1'b0;
                        end
                    end
                end
                S_INCR: begin
                    if (pass_done) begin
                        if (!r_sel_found) begin
                            r_used  <= r_used + UW'(1);
                            r_state <= S_OUT;
                        end else begin
                            r_pos     <= r_sel_idx;
                            r_own     <= r_sel_cum + 16'd1 - r_sel_next;
                            r_cur_cum <= r_sel_cum + 16'd1;
                            r_state   <= (r_sel_idx == '0) ? S_OUT : S_BUBRD;
                        end
                    end
                end
                S_BUBRD: begin
                    r_state <= S_BUBCHK;
                end
                S_BUBCHK: begin
                    if (r_own > above) begin
                        r_cur_cum <= ram_rdata.cum;
                        r_pos     <= r_pos - IW'(1);
                        r_state   <= (r_pos == IW'(1)) ? S_BUBEND : S_BUBRD;
                    end else begin
                        r_state <= S_BUBEND;
                    end
                end
                S_BUBEND: begin
                    r_state <= S_OUT;
                end
                S_OUT: begin
                    if (out_load) begin
                        r_out_data <= r_res;
                        r_state    <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_vld;
    assign o_out_data  = r_out_data;

`include "assert_macros.svh"

    `ASSERT_SYNC(a_used_range, r_used != '0 && r_used <= UW'(MAX_ENTRIES), "entry count out of range")
    `ASSERT_SYNC(a_total_ge_used, 32'(r_total) >= 32'(r_used), "total below entry count")
    `ASSERT_NEXT(a_used_step, 1'b1, r_used == $past(r_used) || r_used == $past(r_used) + UW'(1), "entry count jumped")
    `ASSERT_SYNC(a_flags_excl, !(o_out_valid && o_out_data.escaped && o_out_data.refused), "escaped and refused together")

endmodule

`default_nettype wire

[sv/acfm_ram.sv]
// Simple dual-port table memory, one write and one registered read port.
// Uses nothing from the package.
`default_nettype none

module acfm_ram #(
    parameter int DEPTH = 512,
    parameter int AW    = 9,
    parameter int DW    = 32
) (
    input  wire logic          i_clk,
    input  wire logic          i_we,
    input  wire logic [AW-1:0] i_waddr,
    input  wire logic [DW-1:0] i_wdata,
    input  wire logic          i_re,
    input  wire logic [AW-1:0] i_raddr,
    output logic      [DW-1:0] o_rdata
);

    logic [DW-1:0] r_mem [DEPTH];
    logic [DW-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

[tb/sv/adaptive_cumulative_frequency_model_tb.sv]
// Testbench for the adaptive cumulative frequency model top level.
// Depends on acfm_pkg and adaptive_cumulative_frequency_model; self-contained otherwise.
// Predicts each result from its own model of the table and checks it in order.
`timescale 1ns / 1ps

module adaptive_cumulative_frequency_model_tb;
    import acfm_pkg::*;

    localparam int TBL_DEPTH  = 512;
    localparam int EXPQ_DEPTH = 1024;
    localparam int POOL_DEPTH = 40;

    logic i_clk;
    logic i_rst_n;
    logic i_in_valid;
    logic o_in_ready;
    t_in  i_in_data;
    logic o_out_valid;
    logic i_out_ready;
    t_out o_out_data;

    adaptive_cumulative_frequency_model u_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_in_data  (i_in_data),
        .o_out_valid(o_out_valid),
        .i_out_ready(i_out_ready),
        .o_out_data (o_out_data)
    );

    // Predictor copy of the symbol table.
    logic [15:0] sym_tbl [TBL_DEPTH];
    logic [15:0] cum_tbl [TBL_DEPTH];
    int          n_used;
    int          total;

    // Expected results, in order of acceptance.
    t_out exp_q [EXPQ_DEPTH];
    int   exp_wr = 0;
    int   exp_rd = 0;
    int   n_errors;
    bit   quiet_mode;   // no idling on either side (last part of the run)

    // Pool of symbols so that random updates hit known entries often.
    logic [15:0] sym_pool [POOL_DEPTH];
    int          pool_n = 0;

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    // Watchdog: allows the worst case of every item several times over.
    initial begin
        #(64'd12 * 64'd8_000_000);
        $display("== FAIL ==");
        $finish;
    end

    function automatic int find_sym(input logic [15:0] code);
        for (int k = 0; k < n_used; k++) begin
            if (sym_tbl[k] == code) return k;
        end
        return n_used;
    endfunction

    function automatic int next_cum(input int k);
        return (k + 1 < n_used) ? int'(cum_tbl[k + 1]) : 0;
    endfunction

    // Computes the expected result of one request and advances the table.
    function automatic t_out model_step(input t_in req);
        t_out r;
        int   k;
        int   own;
        int   above;
        logic [15:0] tmp;
        r = '0;
        case (req.mode)
            MODE_ENCODE: begin
                k = find_sym(req.symbol_code);
                if (k >= n_used) begin
                    r.escaped = 1'b1;
                    k = find_sym(ESCAPE_CODE);
                    if (k >= n_used) k = 0;
                end
                r.found_code = sym_tbl[k];
                r.cum_lo     = 16'(next_cum(k));
                r.cum_hi     = cum_tbl[k];
                r.scale_out  = total[15:0];
            end
            MODE_DECODE: begin
                k = n_used;
                while (k > 0) begin
                    k--;
                    if (cum_tbl[k] > req.target_count || k == 0) break;
                end
                r.found_code = sym_tbl[k];
                r.cum_lo     = 16'(next_cum(k));
                r.cum_hi     = cum_tbl[k];
                r.scale_out  = req.scale_in;
            end
            MODE_UPDATE: begin
                k = find_sym(req.symbol_code);
                if (total >= int'(COUNT_MAX) || (k >= n_used && n_used >= TBL_DEPTH)) begin
                    r.refused = 1'b1;
                end else begin
                    total++;
                    if (k >= n_used) begin
                        for (int j = 0; j < n_used; j++) cum_tbl[j] = cum_tbl[j] + 16'd1;
                        sym_tbl[n_used] = req.symbol_code;
                        cum_tbl[n_used] = 16'd1;
                        n_used++;
                    end else begin
                        for (int j = 0; j <= k; j++) cum_tbl[j] = cum_tbl[j] + 16'd1;
                        own = int'(cum_tbl[k]) - next_cum(k);
                        // bubble toward the front while more frequent than the neighbor
                        while (k > 0) begin
                            above = int'(cum_tbl[k - 1]) - int'(cum_tbl[k]);
                            if (own <= above) break;
                            tmp = sym_tbl[k - 1];
                            sym_tbl[k - 1] = sym_tbl[k];
                            sym_tbl[k] = tmp;
                            cum_tbl[k] = cum_tbl[k - 1] - own[15:0];
                            k--;
                        end
                    end
                end
                r.found_code = req.symbol_code;
                r.scale_out  = total[15:0];
            end
            default: r = '0;
        endcase
        return r;
    endfunction

    // Sends one transaction; prediction is made when it is accepted.
    // Valid stays high between back-to-back transactions.
    task automatic send_req(input t_in req);
        if (!quiet_mode && $urandom_range(0, 3) == 0) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data  <= req;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        exp_q[exp_wr % EXPQ_DEPTH] = model_step(req);
        exp_wr++;
    endtask

    function automatic t_in mk_req(input logic [1:0] m, input logic [15:0] s,
                                   input logic [15:0] t, input logic [15:0] sc);
        t_in q;
        q.mode = m;
        q.symbol_code = s;
        q.target_count = t;
        q.scale_in = sc;
        return q;
    endfunction

    task automatic wait_drain();
        i_in_valid <= 1'b0;
        while (exp_wr != exp_rd) @(posedge i_clk);
    endtask

    // Output side: random stall bursts, compare each accepted result.
    initial begin
        t_out exp_r;
        i_out_ready <= 1'b0;
        @(posedge i_rst_n);
        forever begin
            if (!quiet_mode && $urandom_range(0, 3) == 0) begin
                i_out_ready <= 1'b0;
                repeat ($urandom_range(1, 8)) @(posedge i_clk);
            end
            i_out_ready <= 1'b1;
            @(posedge i_clk);
            if (o_out_valid && i_out_ready) begin
                if (exp_wr == exp_rd) begin
                    $display("%0t: unexpected result %h", $time, o_out_data);
                    n_errors++;
                end else begin
                    exp_r = exp_q[exp_rd % EXPQ_DEPTH];
                    exp_rd++;
                    if (o_out_data.found_code !== exp_r.found_code ||
                        o_out_data.cum_lo     !== exp_r.cum_lo     ||
                        o_out_data.cum_hi     !== exp_r.cum_hi     ||
                        o_out_data.scale_out  !== exp_r.scale_out  ||
                        o_out_data.escaped    !== exp_r.escaped    ||
                        o_out_data.refused    !== exp_r.refused) begin
                        $display("%0t: mismatch expected %h actual %h",
                                 $time, exp_r, o_out_data);
                        n_errors++;
                    end
                end
            end
        end
    end

    // Extremes of the fields, every mode, escape handling, unused mode.
    task automatic test_directed();
        send_req(mk_req(MODE_ENCODE, 16'h0000, 16'h0000, 16'h0000));
        send_req(mk_req(MODE_ENCODE, ESCAPE_CODE, 16'hFFFF, 16'hFFFF));
        send_req(mk_req(MODE_DECODE, 16'hFFFF, 16'h0000, 16'hFFFF));
        send_req(mk_req(MODE_DECODE, 16'h0000, 16'hFFFF, 16'h0000));
        send_req(mk_req(MODE_UPDATE, 16'hFFFF, 16'h0000, 16'h0000));
        send_req(mk_req(MODE_UPDATE, 16'h0000, 16'hFFFF, 16'hFFFF));
        send_req(mk_req(MODE_UPDATE, ESCAPE_CODE, 16'h0000, 16'h0000));
        send_req(mk_req(MODE_UPDATE, 16'h0000, 16'h0000, 16'h0000));
        send_req(mk_req(MODE_UPDATE, 16'h0000, 16'h0000, 16'h0000));
        send_req(mk_req(MODE_ENCODE, 16'h0000, 16'h0000, 16'h0000));
        send_req(mk_req(MODE_ENCODE, 16'hFFFF, 16'h0000, 16'h0000));
        send_req(mk_req(MODE_ENCODE, 16'h1234, 16'h0000, 16'h0000));
        for (int t = 0; t < 7; t++)
            send_req(mk_req(MODE_DECODE, 16'h0000, t[15:0], 16'hA5A5));
        send_req(mk_req(MODE_NONE, 16'hFFFF, 16'hFFFF, 16'hFFFF));
        send_req(mk_req(MODE_NONE, 16'h0000, 16'h0000, 16'h0000));
        sym_pool[0] = 16'h0000;
        sym_pool[1] = 16'hFFFF;
        sym_pool[2] = ESCAPE_CODE;
        pool_n = 3;
    endtask

    // Random mix, updates biased toward known symbols to drive bubbling.
    task automatic test_random(input int n_items);
        logic [15:0] s;
        int          sel;
        for (int it = 0; it < n_items; it++) begin
            sel = $urandom_range(0, 99);
            if ($urandom_range(0, 3) != 0 && pool_n != 0)
                s = sym_pool[$urandom_range(0, pool_n - 1)];
            else
                s = 16'($urandom);
            if (sel < 45) begin
                if (find_sym(s) >= n_used && pool_n < POOL_DEPTH) begin
                    sym_pool[pool_n] = s;
                    pool_n++;
                end
                send_req(mk_req(MODE_UPDATE, s, 16'($urandom), 16'($urandom)));
            end else if (sel < 70) begin
                send_req(mk_req(MODE_ENCODE, s, 16'($urandom), 16'($urandom)));
            end else if (sel < 97) begin
                send_req(mk_req(MODE_DECODE, 16'($urandom),
                                16'($urandom_range(0, total + 1)), 16'($urandom)));
            end else begin
                send_req(mk_req(MODE_NONE, 16'($urandom), 16'($urandom),
                                16'($urandom)));
            end
        end
    endtask

    initial begin
        n_errors    = 0;
        quiet_mode  = 1'b0;
        i_rst_n     <= 1'b0;
        i_in_valid  <= 1'b0;
        i_in_data   <= '0;
        for (int k = 0; k < TBL_DEPTH; k++) begin
            sym_tbl[k] = '0;
            cum_tbl[k] = '0;
        end
        sym_tbl[0] = ESCAPE_CODE;
        cum_tbl[0] = 16'd1;
        n_used = 1;
        total  = 1;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed();
        wait_drain();           // sender holds off until all results are back
        test_random(300);
        quiet_mode = 1'b1;
        test_random(100);

        wait_drain();
        repeat (1200) @(posedge i_clk);
        if (n_errors == 0 && exp_wr == exp_rd) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
